/* rtl/core/aging_object_track_table_core_assert.svh */
// Assertion macros shared by the track table RTL.
`ifndef AGING_OBJECT_TRACK_TABLE_CORE_ASSERT_SVH
`define AGING_OBJECT_TRACK_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define AOTT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("track table check failed");

// Next-cycle implication, checked out of reset.
`define AOTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("track table check failed");

`endif

/* rtl/core/aott_pkg.sv */
// Shared constants for the aging object track table.
package aott_pkg;
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int ID_W  = 16;
  localparam int AGE_W = 8;
  localparam logic [AGE_W-1:0] AGE_LIMIT_RST = 8'd5;
  localparam logic [AGE_W-1:0] AGE_MAX       = 8'hFF;
  localparam logic CMD_OBS     = 1'b0;
  localparam logic CMD_TICK    = 1'b1;
  localparam logic KIND_ENTRY  = 1'b0;
  localparam logic KIND_DROP   = 1'b1;
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] REG_AGE_LIMIT = 3'd0;
endpackage

/* rtl/core/aott_mem.sv */
// Single-port-read, single-port-write entry memory with registered read data.
module aott_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

/* rtl/core/aging_object_track_table_core.sv */
// Aging object track table: sequencer around one entry memory.
//
//  channel | direction | ports
//  in      | sink      | in_valid/in_ready, in_command, in_object_id, in_pos_x/y/z
//  out     | source    | out_valid/out_ready, out_report_kind .. out_last_report
//  cfg     | APB slave | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One item at a time; the single memory read port sets the pace. An observation reads
// and compares each entry, then writes it back, or reports a drop when the table is
// full; a tick ages every entry, shifts down the entries after an expired one, then
// reports each remaining entry. Reports wait while out_ready is low.
// rst_n empties the table and restores age_limit to 5; no clearing pass.
`include "aging_object_track_table_core_assert.svh"
module aging_object_track_table_core #(
  parameter int TABLE_DEPTH = aott_pkg::TABLE_DEPTH_DEF,
  parameter int COORD_WIDTH = aott_pkg::COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_command,
  input  logic [aott_pkg::ID_W-1:0] in_object_id,
  input  logic [COORD_WIDTH-1:0]   in_pos_x,
  input  logic [COORD_WIDTH-1:0]   in_pos_y,
  input  logic [COORD_WIDTH-1:0]   in_pos_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_report_kind,
  output logic [aott_pkg::ID_W-1:0] out_reported_id,
  output logic [COORD_WIDTH-1:0]   out_out_x,
  output logic [COORD_WIDTH-1:0]   out_out_y,
  output logic [COORD_WIDTH-1:0]   out_out_z,
  output logic                     out_last_report,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [aott_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import aott_pkg::*;

  localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam int EW   = ID_W + 3 * COORD_WIDTH + AGE_W;
  localparam logic [CNTW-1:0] DEPTH_C = CNTW'(TABLE_DEPTH);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_OBS_RD  = 4'd1;
  localparam logic [3:0] S_OBS_CMP = 4'd2;
  localparam logic [3:0] S_OBS_WR  = 4'd3;
  localparam logic [3:0] S_DROP    = 4'd4;
  localparam logic [3:0] S_AGE_RD  = 4'd5;
  localparam logic [3:0] S_AGE_WB  = 4'd6;
  localparam logic [3:0] S_SH_RD   = 4'd7;
  localparam logic [3:0] S_SH_WR   = 4'd8;
  localparam logic [3:0] S_REP_RD  = 4'd9;
  localparam logic [3:0] S_REP_OUT = 4'd10;

  logic [3:0]             state_r, state_nxt;
  logic [CNTW-1:0]        count_r, count_nxt;
  logic [IW-1:0]          idx_r, idx_nxt;
  logic [IW-1:0]          hit_r, hit_nxt;
  logic                   found_r, found_nxt;
  logic [IW-1:0]          victim_r, victim_nxt;
  logic                   expire_r, expire_nxt;
  logic [AGE_W-1:0]       age_limit_r;
  logic                   cmd_r;
  logic [ID_W-1:0]        id_r;
  logic [COORD_WIDTH-1:0] x_r, y_r, z_r;

  logic                   out_valid_r;
  logic                   kind_r, last_r;
  logic [ID_W-1:0]        oid_r;
  logic [COORD_WIDTH-1:0] ox_r, oy_r, oz_r;
  logic                   out_load;
  logic                   load_kind, load_last;
  logic [ID_W-1:0]        load_id;
  logic [COORD_WIDTH-1:0] load_x, load_y, load_z;

  logic                   rd_en, wr_en;
  logic [IW-1:0]          rd_addr, wr_addr;
  logic [EW-1:0]          rd_data, wr_data;

  logic [ID_W-1:0]        rd_id;
  logic [COORD_WIDTH-1:0] rd_x, rd_y, rd_z;
  logic [AGE_W-1:0]       rd_age, age_inc;
  logic [CNTW-1:0]        idx_ext, idx_p1, idx_p2, victim_p1;
  logic                   out_free, in_acc;

  assign rd_age = rd_data[AGE_W-1:0];
  assign rd_z   = rd_data[AGE_W +: COORD_WIDTH];
  assign rd_y   = rd_data[AGE_W + COORD_WIDTH +: COORD_WIDTH];
  assign rd_x   = rd_data[AGE_W + 2 * COORD_WIDTH +: COORD_WIDTH];
  assign rd_id  = rd_data[AGE_W + 3 * COORD_WIDTH +: ID_W];

  assign age_inc   = (rd_age == AGE_MAX) ? AGE_MAX : rd_age + 1'b1;
  assign idx_ext   = CNTW'(idx_r);
  assign idx_p1    = idx_ext + 1'b1;
  assign idx_p2    = idx_ext + CNTW'(2);
  assign victim_p1 = CNTW'(victim_nxt) + 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;

  aott_mem #(.DEPTH(TABLE_DEPTH), .WIDTH(EW)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    hit_nxt    = hit_r;
    found_nxt  = found_r;
    victim_nxt = victim_r;
    expire_nxt = expire_r;
    rd_en      = 1'b0;
    rd_addr    = idx_r;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_data    = rd_data;
    out_load   = 1'b0;
    load_kind  = KIND_ENTRY;
    load_id    = rd_id;
    load_x     = rd_x;
    load_y     = rd_y;
    load_z     = rd_z;
    load_last  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          idx_nxt    = '0;
          found_nxt  = 1'b0;
          expire_nxt = 1'b0;
          if (in_command == CMD_OBS) begin
            state_nxt = (count_r == '0) ? S_OBS_WR : S_OBS_RD;
          end else begin
            state_nxt = (count_r == '0) ? S_IDLE : S_AGE_RD;
          end
        end
      end
      S_OBS_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_OBS_CMP;
      end
      S_OBS_CMP: begin
        if (rd_id == id_r) begin
          found_nxt = 1'b1;
          hit_nxt   = idx_r;
        end
        if (idx_p1 == count_r) begin
          state_nxt = S_OBS_WR;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_OBS_RD;
        end
      end
      S_OBS_WR: begin
        wr_data = {id_r, x_r, y_r, z_r, {AGE_W{1'b0}}};
        if (found_r) begin
          wr_en     = 1'b1;
          wr_addr   = hit_r;
          state_nxt = S_IDLE;
        end else if (count_r < DEPTH_C) begin
          wr_en     = 1'b1;
          wr_addr   = count_r[IW-1:0];
          count_nxt = count_r + 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DROP;
        end
      end
      S_DROP: begin
        load_kind = KIND_DROP;
        load_id   = id_r;
        load_x    = x_r;
        load_y    = y_r;
        load_z    = z_r;
        load_last = 1'b1;
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_AGE_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_AGE_WB;
      end
      S_AGE_WB: begin
        wr_en   = 1'b1;
        wr_data = {rd_id, rd_x, rd_y, rd_z, age_inc};
        if (age_inc > age_limit_r) begin
          expire_nxt = 1'b1;
          victim_nxt = idx_r;
        end
        if (idx_p1 != count_r) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_AGE_RD;
        end else if (expire_nxt && (victim_p1 < count_r)) begin
          idx_nxt   = victim_nxt;
          state_nxt = S_SH_RD;
        end else begin
          // no shift needed: drop the tail entry if it expired
          count_nxt = count_r - CNTW'(expire_nxt);
          idx_nxt   = '0;
          state_nxt = (count_nxt == '0) ? S_IDLE : S_REP_RD;
        end
      end
      S_SH_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_p1[IW-1:0];
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        wr_en = 1'b1;
        if (idx_p2 == count_r) begin
          count_nxt = count_r - 1'b1;
          idx_nxt   = '0;
          state_nxt = S_REP_RD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SH_RD;
        end
      end
      S_REP_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_REP_OUT;
      end
      S_REP_OUT: begin
        load_last = (idx_p1 == count_r);
        if (out_free) begin
          out_load = 1'b1;
          if (load_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_REP_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      age_limit_r <= AGE_LIMIT_RST;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (psel && penable && pwrite && (paddr[ADDR_W-1] == REG_AGE_LIMIT[ADDR_W-1])) begin
        age_limit_r <= pwdata[AGE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    hit_r    <= hit_nxt;
    found_r  <= found_nxt;
    victim_r <= victim_nxt;
    expire_r <= expire_nxt;
    if (in_acc) begin
      cmd_r <= in_command;
      id_r  <= in_object_id;
      x_r   <= in_pos_x;
      y_r   <= in_pos_y;
      z_r   <= in_pos_z;
    end
    if (out_load) begin
      kind_r <= load_kind;
      oid_r  <= load_id;
      ox_r   <= load_x;
      oy_r   <= load_y;
      oz_r   <= load_z;
      last_r <= load_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_report_kind = kind_r;
  assign out_reported_id = oid_r;
  assign out_out_x       = ox_r;
  assign out_out_y       = oy_r;
  assign out_out_z       = oz_r;
  assign out_last_report = last_r;

  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == REG_AGE_LIMIT[ADDR_W-1]) ?
                  {{(32-AGE_W){1'b0}}, age_limit_r} : 32'd0;

  `AOTT_ASSERT_NOW(a_count_bound, 1'b1, count_r <= DEPTH_C)
  `AOTT_ASSERT_NOW(a_no_rw_overlap, wr_en, !rd_en)
  `AOTT_ASSERT_NEXT(a_tick_starts, in_acc && (in_command == CMD_TICK) && (count_r != '0),
                    (state_r == S_AGE_RD) && (cmd_r == CMD_TICK))
  `AOTT_ASSERT_NOW(a_drop_full, out_load && (load_kind == KIND_DROP), count_r == DEPTH_C)
endmodule
